>>> rtl/permutation_unrank_lexicographic_macros.svh
// Assertion helpers shared by the checker files.
// Each macro expands to one labeled concurrent assertion on the rising clock,
// disabled while the synchronous reset is held.
`ifndef PERMUTATION_UNRANK_LEXICOGRAPHIC_MACROS_SVH
`define PERMUTATION_UNRANK_LEXICOGRAPHIC_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PUL_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PUL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/pul_pkg.sv
package pul_pkg;

    // Field widths of the ports.
    localparam int RANK_W   = 63;
    localparam int POS_W    = 4;
    localparam int ELEM_W   = 5;
    localparam int LEN_W    = 5;

    // Default number of elements supported by the datapath.
    localparam int DEF_MAX_ELEMENTS = 16;

    // Dividend bits handled by one division stage.
    localparam int CHUNK_W = 8;

    typedef logic [LEN_W-1:0] t_len;

    // Permutation length after reset.
    localparam t_len LEN_RESET = 5'd16;

endpackage

>>> rtl/pul_factoradic.sv
module pul_factoradic
    import pul_pkg::*;
#(
    parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
    localparam int DW = $clog2(MAX_ELEMENTS)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic [RANK_W-1:0]                i_rank,
    output logic                             o_valid,
    output logic [MAX_ELEMENTS-1:0][DW-1:0]  o_digits
);

    // The rank is divided by 2, 3, ..., MAX_ELEMENTS in turn. Each division is
    // a long division by a constant, one chunk of the dividend per stage, most
    // significant chunk first. The quotient bits replace the dividend bits in
    // place and the final remainder becomes the factoradic digit.
    localparam int NCH  = (RANK_W + CHUNK_W - 1) / CHUNK_W;
    localparam int PW   = NCH * CHUNK_W;
    localparam int NSTG = (MAX_ELEMENTS - 1) * NCH;

    logic [NSTG:0]                      stg_valid;
    logic [PW-1:0]                      stg_quo [0:NSTG];
    logic [DW-1:0]                      stg_rem [0:NSTG];
    logic [MAX_ELEMENTS-1:0][DW-1:0]    stg_dig [0:NSTG];

    // Stage zero input comes straight from the ports.
    assign stg_valid[0] = i_valid;
    assign stg_quo[0]   = PW'(i_rank);
    assign stg_rem[0]   = '0;
    assign stg_dig[0]   = '0;

    for (genvar s = 0; s < NSTG; s++) begin : g_stage
        localparam int DIVISOR   = s / NCH + 2;
        localparam int CHUNK_IDX = s % NCH;
        localparam int MSB       = PW - 1 - CHUNK_IDX * CHUNK_W;
        localparam logic [DW:0] DIV_V = DIVISOR[DW:0];

        logic [PW-1:0]                   n_quo;
        logic [DW-1:0]                   n_rem;
        logic [MAX_ELEMENTS-1:0][DW-1:0] n_dig;
        logic [DW:0]                     part;
        logic [CHUNK_W-1:0]              bits_in;
        logic [CHUNK_W-1:0]              bits_q;

        logic                            r_valid;
        logic [PW-1:0]                   r_quo;
        logic [DW-1:0]                   r_rem;
        logic [MAX_ELEMENTS-1:0][DW-1:0] r_dig;

        // Restoring division of one chunk by the stage's constant divisor.
        always_comb begin
            n_quo   = stg_quo[s];
            n_dig   = stg_dig[s];
            bits_in = stg_quo[s][MSB -: CHUNK_W];
            bits_q  = '0;
            part    = '0;
            n_rem   = (CHUNK_IDX == 0) ? '0 : stg_rem[s];
            for (int b = CHUNK_W - 1; b >= 0; b--) begin
                part = {n_rem, bits_in[b]};
                if (part >= DIV_V) begin
                    part      = part - DIV_V;
                    bits_q[b] = 1'b1;
                end
                n_rem = part[DW-1:0];
            end
            n_quo[MSB -: CHUNK_W] = bits_q;
            // The last chunk leaves the remainder, which is this divisor's digit.
            if (CHUNK_IDX == NCH - 1) begin
                n_dig[DIVISOR-1] = n_rem;
            end
        end

        // Valid bit travels with the data and freezes on a stall.
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid <= 1'b0;
            end else if (i_en) begin
                r_valid <= stg_valid[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo <= n_quo;
                r_rem <= n_rem;
                r_dig <= n_dig;
            end
        end

        assign stg_valid[s+1] = r_valid;
        assign stg_quo[s+1]   = r_quo;
        assign stg_rem[s+1]   = r_rem;
        assign stg_dig[s+1]   = r_dig;
    end

    assign o_valid  = stg_valid[NSTG];
    assign o_digits = stg_dig[NSTG];

endmodule

>>> rtl/permutation_unrank_lexicographic.sv
// A rank transfer passes through the division pipeline and then the element serializer.
// The serializer shows one element per cycle while the receiver is ready; the division
// pipeline takes a rank every cycle unless its output waits for a busy serializer, so
// the element serializer sets the rate.
// Reset is synchronous and active low; it empties the pipeline and sets the length to 16.
module permutation_unrank_lexicographic
    import pul_pkg::*;
#(
    parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [RANK_W-1:0] i_rank,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [POS_W-1:0]  o_position,
    output logic [ELEM_W-1:0] o_element,
    output logic              o_last,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  t_len              i_cfg_perm_length
);

    localparam int   DW      = $clog2(MAX_ELEMENTS);
    localparam int   NW      = $clog2(MAX_ELEMENTS + 1);
    localparam t_len MAX_LEN = LEN_W'(MAX_ELEMENTS);

    // Configuration register.
    t_len r_perm_length;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_perm_length <= LEN_RESET;
        end else if (i_cfg_valid) begin
            r_perm_length <= i_cfg_perm_length;
        end
    end

    // Effective length: zero counts as one and large values saturate.
    logic [NW-1:0] eff_len;
    logic [NW-1:0] len_m1;
    logic [DW-1:0] last_pos;

    always_comb begin
        if (r_perm_length == '0) begin
            eff_len = NW'(1);
        end else if (r_perm_length > MAX_LEN) begin
            eff_len = NW'(MAX_ELEMENTS);
        end else begin
            eff_len = NW'(r_perm_length);
        end
    end

    assign len_m1   = eff_len - NW'(1);
    assign last_pos = len_m1[DW-1:0];

    // Factoradic digit pipeline.
    logic                            pipe_en;
    logic                            f_valid;
    logic [MAX_ELEMENTS-1:0][DW-1:0] f_digits;

    pul_factoradic #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_factoradic (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (pipe_en),
        .i_valid  (i_valid),
        .i_rank   (i_rank),
        .o_valid  (f_valid),
        .o_digits (f_digits)
    );

    // Serializer state: the digits in position order and the pool of unused values.
    logic                r_busy;
    logic [DW-1:0]       r_pos;
    logic [ELEM_W-1:0]   r_pool [MAX_ELEMENTS];
    logic [DW-1:0]       r_pdig [MAX_ELEMENTS];
    logic                r_out_valid;
    logic [POS_W-1:0]    r_position;
    logic [ELEM_W-1:0]   r_element;
    logic                r_last;

    logic                n_busy;
    logic [DW-1:0]       n_pos;
    logic [ELEM_W-1:0]   n_pool [MAX_ELEMENTS];
    logic [DW-1:0]       n_pdig [MAX_ELEMENTS];
    logic                n_out_valid;
    logic [POS_W-1:0]    n_position;
    logic [ELEM_W-1:0]   n_element;
    logic                n_last;

    logic                emit;
    logic                take;
    logic                at_last;
    logic [DW-1:0]       sel;
    logic [NW-1:0]       idx;
    logic [DW-1:0]       load_dig [MAX_ELEMENTS];

    assign sel     = r_pdig[0];
    assign at_last = (r_pos == last_pos);
    assign emit    = r_busy && (!r_out_valid || i_ready);
    assign take    = f_valid && (!r_busy || (emit && at_last));
    assign pipe_en = !f_valid || take;
    assign o_ready = pipe_en;

    // The least significant digit belongs to the last position, so reverse by length.
    always_comb begin
        idx = '0;
        for (int j = 0; j < MAX_ELEMENTS; j++) begin
            idx = len_m1 - NW'(j);
            if (NW'(j) < eff_len) begin
                load_dig[j] = f_digits[idx[DW-1:0]];
            end else begin
                load_dig[j] = '0;
            end
        end
    end

    // Each emitted element is picked from the pool, which then closes the gap.
    always_comb begin
        n_busy      = r_busy;
        n_pos       = r_pos;
        n_pool      = r_pool;
        n_pdig      = r_pdig;
        n_out_valid = r_out_valid && !i_ready;
        n_position  = r_position;
        n_element   = r_element;
        n_last      = r_last;
        if (emit) begin
            n_out_valid = 1'b1;
            n_position  = POS_W'(r_pos);
            n_element   = r_pool[sel];
            n_last      = at_last;
            for (int m = 0; m < MAX_ELEMENTS - 1; m++) begin
                n_pool[m] = (DW'(m) < sel) ? r_pool[m] : r_pool[m+1];
                n_pdig[m] = r_pdig[m+1];
            end
            n_pdig[MAX_ELEMENTS-1] = '0;
            n_pos = r_pos + DW'(1);
            if (at_last) begin
                n_busy = 1'b0;
            end
        end
        if (take) begin
            n_busy = 1'b1;
            n_pos  = '0;
            n_pdig = load_dig;
            for (int j = 0; j < MAX_ELEMENTS; j++) begin
                n_pool[j] = ELEM_W'(j + 1);
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_pool     <= n_pool;
        r_pdig     <= n_pdig;
        r_position <= n_position;
        r_element  <= n_element;
        r_last     <= n_last;
    end

    assign o_valid    = r_out_valid;
    assign o_position = r_position;
    assign o_element  = r_element;
    assign o_last     = r_last;

endmodule

>>> rtl/pul_checker.sv
`include "permutation_unrank_lexicographic_macros.svh"

module pul_checker
    import pul_pkg::*;
#(
    parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              i_ready,
    input logic [POS_W-1:0]  o_position,
    input logic [ELEM_W-1:0] o_element,
    input logic              o_last
);

    localparam logic [ELEM_W-1:0] MAX_EL = ELEM_W'(MAX_ELEMENTS);

    logic xfer;
    logic out_held;
    logic elem_ok;

    assign xfer     = o_valid && i_ready;
    assign out_held = o_valid && !i_ready;
    assign elem_ok  = (o_element != '0) && (o_element <= MAX_EL);

    // A result that waits keeps its payload.
    `PUL_ASSERT_NEXT(a_out_hold, out_held, o_valid && $stable(o_position) && $stable(o_element) && $stable(o_last), "result changed while stalled")

    // Results inside one permutation follow position order without gaps.
    `PUL_ASSERT_SAME(a_pos_step, $past(xfer && !o_last) && o_valid, o_position == $past(o_position) + 4'd1, "position did not advance by one")

    // A new permutation starts at position zero.
    `PUL_ASSERT_SAME(a_pos_start, $past(xfer && o_last) && o_valid, o_position == '0, "permutation did not start at position zero")

    // Every element is one of the values 1..MAX_ELEMENTS.
    `PUL_ASSERT_SAME(a_elem_range, o_valid, elem_ok, "element out of range")

endmodule

bind permutation_unrank_lexicographic pul_checker #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
) u_pul_checker (.*);

>>> sim/testbench.sv
module testbench;
    import pul_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = (DEF_MAX_ELEMENTS - 1) * 8 + 10;

    // One element of a permutation as the block presents it.
    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic [ELEM_W-1:0] element;
        logic              last;
    } perm_elem_t;

    // Predicts the permutation elements of each accepted rank and checks the
    // element transfers against them in order.
    class unrank_checker;
        perm_elem_t expected_elems[$];
        t_len       length_reg;
        int         failures;

        function new();
            length_reg = LEN_RESET;
            failures = 0;
        endfunction

        function void set_length(t_len value);
            length_reg = value;
        endfunction

        // A length of zero acts as one, and lengths above the maximum saturate.
        function int unsigned active_length();
            int unsigned n;
            n = length_reg;
            if (n < 1) begin
                n = 1;
            end
            if (n > DEF_MAX_ELEMENTS) begin
                n = DEF_MAX_ELEMENTS;
            end
            return n;
        endfunction

        function int pending();
            return expected_elems.size();
        endfunction

        function void add_rank(logic [RANK_W-1:0] rank);
            int unsigned n;
            logic [63:0] rest;
            logic [63:0] divisor;
            int unsigned digit [DEF_MAX_ELEMENTS];
            int unsigned unused_vals[$];
            int unsigned sel;
            perm_elem_t e;
            n = active_length();
            rest = {1'b0, rank};
            // Factoradic digits; the final quotient is dropped, so the rank wraps at n!.
            for (int unsigned k = 0; k < n; k++) begin
                divisor = 64'(k + 1);
                digit[n - 1 - k] = 32'(rest % divisor);
                rest = rest / divisor;
            end
            for (int unsigned k = 0; k < n; k++) begin
                unused_vals.push_back(k + 1);
            end
            // Each digit picks and removes an entry from the values still unused.
            for (int unsigned k = 0; k < n; k++) begin
                sel = digit[k];
                if (sel >= unused_vals.size()) begin
                    sel = unused_vals.size() - 1;
                end
                e.position = POS_W'(k);
                e.element = ELEM_W'(unused_vals[sel]);
                e.last = (k + 1 == n);
                unused_vals.delete(sel);
                expected_elems.push_back(e);
            end
        endfunction

        function void check_result(logic [POS_W-1:0] position, logic [ELEM_W-1:0] element,
                                   logic last);
            perm_elem_t want;
            if (expected_elems.size() == 0) begin
                $display("%0t: unexpected element transfer: position %0d element %0d last %0d",
                         $time, position, element, last);
                failures++;
                return;
            end
            want = expected_elems.pop_front();
            if (position !== want.position) begin
                $display("%0t: position mismatch: expected %0d, actual %0d",
                         $time, want.position, position);
                failures++;
            end
            if (element !== want.element) begin
                $display("%0t: element mismatch at position %0d: expected %0d, actual %0d",
                         $time, want.position, want.element, element);
                failures++;
            end
            if (last !== want.last) begin
                $display("%0t: last mismatch at position %0d: expected %0d, actual %0d",
                         $time, want.position, want.last, last);
                failures++;
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [RANK_W-1:0] i_rank;
    logic              o_valid;
    logic              i_ready = 1'b1;
    logic [POS_W-1:0]  o_position;
    logic [ELEM_W-1:0] o_element;
    logic              o_last;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    t_len              i_cfg_perm_length;

    unrank_checker perm_check = new();

    int in_idle_pct = 0;
    int out_idle_pct = 0;
    int ready_hold = 0;
    int cycle_count = 0;

    permutation_unrank_lexicographic dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_rank            (i_rank),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_position        (o_position),
        .o_element         (o_element),
        .o_last            (o_last),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_perm_length (i_cfg_perm_length)
    );

    always #2 i_clk = ~i_clk;

    // The receiver stalls in bursts of random length, started at a rate set by out_idle_pct.
    always @(negedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold--;
            i_ready <= 1'b0;
        end else if ($urandom_range(1, 100) <= out_idle_pct) begin
            ready_hold = $urandom_range(0, 6);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Every element transfer is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            perm_check.check_result(o_position, o_element, o_last);
        end
    end

    // Guard against a hung handshake.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    function automatic logic [63:0] factorial(int unsigned n);
        logic [63:0] f;
        f = 64'd1;
        for (int unsigned k = 2; k <= n; k++) begin
            f = f * k;
        end
        return f;
    endfunction

    // Mostly in-range ranks, with wrapped, boundary and small ones mixed in.
    function automatic logic [RANK_W-1:0] random_rank(int unsigned n);
        logic [63:0] raw;
        logic [63:0] span;
        raw = {$urandom, $urandom};
        span = factorial(n);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return RANK_W'(raw % span);
            5, 6: return RANK_W'(raw);
            7: return RANK_W'(span - 1 + $urandom_range(0, 2));
            8: return RANK_W'($urandom_range(0, 30));
            default: return RANK_W'(span * $urandom_range(1, 1000) + raw % span);
        endcase
    endfunction

    // Presents one rank, possibly after an idle gap, and waits for its transfer.
    task automatic send_rank(logic [RANK_W-1:0] rank);
        @(negedge i_clk);
        if ($urandom_range(1, 100) <= in_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_rank <= rank;
        do @(posedge i_clk); while (!o_ready);
        perm_check.add_rank(rank);
    endtask

    // Stops sending and waits until every predicted element has arrived.
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (perm_check.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Writes the length register once the block has gone idle.
    task automatic write_length(t_len value);
        drain();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_perm_length <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        perm_check.set_length(value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(t_len value, int count, int idle_pct);
        write_length(value);
        in_idle_pct = idle_pct;
        out_idle_pct = idle_pct;
        repeat (count) begin
            send_rank(random_rank(perm_check.active_length()));
        end
    endtask

    initial begin
        t_len phase_len [11];
        int phase_idle [11];

        phase_len = '{5'd5, 5'd16, 5'd1, 5'd8, 5'd24, 5'd2, 5'd13, 5'd0, 5'd3,
                      5'd16, 5'd11};
        phase_idle = '{30, 0, 20, 40, 10, 25, 0, 35, 15, 30, 0};

        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_rank = '0;
        i_cfg_valid = 1'b0;
        i_cfg_perm_length = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed ranks at the reset length of sixteen: identity, reverse, wrap
        // at n!, all ones and alternating bit patterns.
        in_idle_pct = 20;
        out_idle_pct = 20;
        send_rank('0);
        send_rank(RANK_W'(1));
        send_rank(RANK_W'(factorial(16) - 1));
        send_rank(RANK_W'(factorial(16)));
        send_rank({RANK_W{1'b1}});
        send_rank(63'h2AAA_AAAA_AAAA_AAAA);
        send_rank(63'h5555_5555_5555_5555);

        // A length of zero behaves as a length of one.
        write_length(5'd0);
        send_rank('0);
        send_rank({RANK_W{1'b1}});
        write_length(5'd1);
        send_rank(RANK_W'(3));

        // Short lengths, including ranks that wrap.
        write_length(5'd2);
        send_rank('0);
        send_rank(RANK_W'(1));
        send_rank(RANK_W'(2));
        write_length(5'd3);
        send_rank('0);
        send_rank(RANK_W'(5));
        send_rank(RANK_W'(6));

        // Lengths above the maximum saturate to sixteen.
        write_length(5'd31);
        send_rank(RANK_W'(factorial(16) - 1));
        send_rank(RANK_W'(1));
        write_length(5'd17);
        send_rank(RANK_W'(2));

        // Random ranks over a sweep of lengths; the last phase runs without idling.
        for (int p = 0; p < 11; p++) begin
            random_phase(phase_len[p], 33, phase_idle[p]);
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (perm_check.failures == 0 && perm_check.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/pul_pkg.sv
rtl/pul_factoradic.sv
rtl/permutation_unrank_lexicographic.sv
rtl/pul_checker.sv
sim/testbench.sv
